[design/ads_pkg.sv]
// Package for the adaptive delta sample decoder.
// Holds the parse phase enum, the queue item and control structs, and shared constants.
// No dependencies.
`default_nettype none

package ads_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDE  = 2'd0;
    localparam logic [1:0] CFG_PRED  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_CONT,
        PH_LOW
    } t_phase;

    // one finished code word on its way to the back end
    typedef struct packed {
        logic [SAMPLE_W-1:0] code;
        logic                last;
    } t_code_item;

    // mode and restart control from the register file
    typedef struct packed {
        logic             restart;
        logic             wide;
        logic             use_pred;
        logic [CFG_W-1:0] count;
    } t_ctrl;

endpackage

`default_nettype wire

[design/adaptive_delta_sample_decoder.sv]
// Top level of the adaptive delta sample decoder: configuration registers,
// front end, code word queue and back end. Depends on ads_pkg and the ads_* modules.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready / i_stream_byte): one compressed
//   byte per item, parsed MSB first at one bit per cycle unless a full queue
//   stalls the front end; the next byte is taken on the cycle the last
//   bit is parsed.
// - Output channel (o_out_valid / i_out_ready): 0 to 3 samples per byte,
//   each with o_final_sample set on the last sample of the configured count.
//   A sample reaches the output through the queue and then the output
//   register.
// - The back end takes a new code word as the last sample is taken; with
//   prediction enabled the saturated prediction is first formed in a separate step.
// - A 4-entry code word queue decouples the two halves: a stalled receiver
//   first fills the queue, then the front end holds on the bit that
//   completes a code word, and finally o_in_ready drops.
// - Configuration: i_cfg_we / i_cfg_index / i_cfg_data, write only, taken
//   at once. Writing any of the three registers restarts decoding with the
//   current mode and reloads the sample counter; an unused index is ignored.
// - Reset: synchronous on i_rst_n low; 8-bit mode, no prediction, count 0.
//   With the count at zero every byte is taken and dropped.
`default_nettype none

module adaptive_delta_sample_decoder #(
    parameter int COUNT_BITS = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [15:0] o_sample_value,
    output logic        o_final_sample
);
    import ads_pkg::*;

    logic             r_wide, n_wide;
    logic             r_use_pred, n_use_pred;
    logic [CFG_W-1:0] r_count, n_count;
    logic             restart;
    t_ctrl            ctrl;

    t_code_item       push_item, head_item;
    logic             push, pop, q_empty, q_full;

    // register file; the new values go straight to the units so a restart
    // sees the value being written
    always_comb begin
        n_wide     = r_wide;
        n_use_pred = r_use_pred;
        n_count    = r_count;
        restart    = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDE: begin
                    n_wide  = i_cfg_data[0];
                    restart = 1'b1;
                end
                CFG_PRED: begin
                    n_use_pred = i_cfg_data[0];
                    restart    = 1'b1;
                end
                CFG_COUNT: begin
                    n_count = i_cfg_data;
                    restart = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide     <= 1'b0;
            r_use_pred <= 1'b0;
            r_count    <= '0;
        end else begin
            r_wide     <= n_wide;
            r_use_pred <= n_use_pred;
            r_count    <= n_count;
        end
    end

    assign ctrl.restart  = restart;
    assign ctrl.wide     = n_wide;
    assign ctrl.use_pred = n_use_pred;
    assign ctrl.count    = n_count;

    ads_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    ads_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (restart),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ads_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_item         (head_item),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_value (o_sample_value),
        .o_final_sample (o_final_sample)
    );

endmodule

`default_nettype wire

[design/ads_front.sv]
// Front end: takes stream bytes, walks them one bit per cycle unless a full queue
// stalls it, through the prefix/low-part parser and pushes finished code words. Depends on ads_pkg.
`default_nettype none

module ads_front #(
    parameter int COUNT_BITS = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ads_pkg::t_ctrl      i_ctrl,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [7:0]          i_stream_byte,
    input  wire                 i_q_full,
    output logic                o_push,
    output ads_pkg::t_code_item o_item
);
    import ads_pkg::*;

    logic [7:0]            r_byte;
    logic [3:0]            r_bits_left;
    t_phase                r_phase, n_phase;
    logic                  r_grp, n_grp;
    logic [3:0]            r_low_left, n_low_left;
    logic [3:0]            r_lw, n_lw;
    logic [SAMPLE_W-1:0]   r_code;
    logic [COUNT_BITS-1:0] r_left;

    logic                  bit_in, per2, shift_in, done;
    logic                  active, stall, step;
    logic [SAMPLE_W-1:0]   mask, code_word;
    logic [3:0]            top;
    logic [4:0]            lw_sum;

    assign bit_in = r_byte[7];
    assign per2   = i_ctrl.wide && (r_lw < 4'd5);
    assign mask   = i_ctrl.wide ? 16'hFFFF : 16'h00FF;
    assign active = (r_bits_left != 4'd0) && (r_left != '0);
    assign stall  = active && done && i_q_full;
    assign step   = (r_bits_left != 4'd0) && !stall;
    assign o_in_ready = (r_bits_left == 4'd0) || ((r_bits_left == 4'd1) && step);

    // parser next state
    always_comb begin
        n_phase    = r_phase;
        n_grp      = r_grp;
        n_low_left = r_low_left;
        done       = 1'b0;
        shift_in   = 1'b0;
        unique case (r_phase)
            PH_DATA: begin
                shift_in = 1'b1;
                if (!per2 || r_grp) begin
                    n_grp   = 1'b0;
                    n_phase = PH_CONT;
                end else begin
                    n_grp = 1'b1;
                end
            end
            PH_CONT: begin
                if (bit_in) begin
                    n_phase = PH_DATA;
                end else begin
                    n_low_left = r_lw;
                    n_phase    = PH_LOW;
                    done       = (r_lw == 4'd0);
                end
            end
            PH_LOW: begin
                shift_in = 1'b1;
                if (r_low_left != 4'd0) begin
                    n_low_left = r_low_left - 4'd1;
                end
                done = (r_low_left <= 4'd1);
            end
            default: begin
                n_phase = PH_DATA;
            end
        endcase
        if (done) begin
            n_phase    = PH_DATA;
            n_grp      = 1'b0;
            n_low_left = 4'd0;
        end
    end

    // code word and next low-part width (top set bit at 2 or above, else 1)
    always_comb begin
        code_word = shift_in ? ({r_code[SAMPLE_W-2:0], bit_in} & mask) : r_code;
        top = 4'd1;
        for (int i = 2; i < SAMPLE_W; i++) begin
            if (code_word[i]) begin
                top = 4'(i);
            end
        end
        lw_sum = {1'b0, r_lw} + {1'b0, top};
        n_lw   = lw_sum[4:1];
    end

    assign o_push      = step && active && done;
    assign o_item.code = code_word;
    assign o_item.last = (r_left == COUNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_left <= 4'd0;
            r_phase     <= PH_DATA;
            r_grp       <= 1'b0;
            r_low_left  <= 4'd0;
            r_lw        <= 4'd4;
            r_code      <= '0;
            r_left      <= '0;
        end else if (i_ctrl.restart) begin
            r_bits_left <= 4'd0;
            r_phase     <= PH_DATA;
            r_grp       <= 1'b0;
            r_low_left  <= 4'd0;
            r_lw        <= i_ctrl.wide ? 4'd8 : 4'd4;
            r_code      <= '0;
            r_left      <= COUNT_BITS'(i_ctrl.count);
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_bits_left <= 4'd8;
            end else if (step) begin
                r_bits_left <= r_bits_left - 4'd1;
            end
            if (step && active) begin
                r_phase    <= n_phase;
                r_grp      <= n_grp;
                r_low_left <= n_low_left;
                r_code     <= done ? '0 : code_word;
                if (done) begin
                    r_lw   <= n_lw;
                    r_left <= r_left - COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_stream_byte;
        end else if (step) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
    end

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= 4'd8) else $error("front bit counter out of range");
    // a mode write may land while a two-bit group is half taken; it clears it
    a_grp_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp |-> (r_phase == PH_DATA) && (i_ctrl.wide || i_ctrl.restart))
        else $error("second group bit outside wide data phase");

endmodule

`default_nettype wire

[design/ads_queue.sv]
// Short queue of finished code words between front and back end.
// Depends on ads_pkg.
`default_nettype none

module ads_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_clear,
    input  wire                 i_push,
    input  ads_pkg::t_code_item i_item,
    input  wire                 i_pop,
    output ads_pkg::t_code_item o_item,
    output logic                o_empty,
    output logic                o_full
);
    import ads_pkg::*;

    t_code_item            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, r_rd;
    logic [QUEUE_AW:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QUEUE_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QUEUE_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW + 1)'(QUEUE_DEPTH)) else $error("queue over capacity");

endmodule

`default_nettype wire

[design/ads_back.sv]
// Back end: turns code words into deltas, adds them to the previous sample or
// the saturated second-order prediction, and holds the output register. Uses ads_pkg.
`default_nettype none

module ads_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ads_pkg::t_ctrl       i_ctrl,
    input  ads_pkg::t_code_item  i_item,
    input  wire                  i_q_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [15:0]          o_sample_value,
    output logic                 o_final_sample
);
    import ads_pkg::*;

    logic                r_out_valid, r_out_final, r_pend;
    logic [SAMPLE_W-1:0] r_out_value, r_prev, r_pred, r_samp, r_half;

    logic [SAMPLE_W-1:0] mask, delta, half, base, sample;
    logic signed [18:0]  s_ext, h_ext, p_ext, nx, lim, sat;

    function automatic logic signed [18:0] sext(input logic [SAMPLE_W-1:0] v,
                                                input logic wide);
        return wide ? $signed({{3{v[15]}}, v}) : $signed({{11{v[7]}}, v[7:0]});
    endfunction

    assign mask = i_ctrl.wide ? 16'hFFFF : 16'h00FF;
    assign o_pop = !i_q_empty && !r_pend && (!r_out_valid || i_out_ready);

    always_comb begin
        delta = {1'b0, i_item.code[SAMPLE_W-1:1]};
        if (!i_item.code[0]) begin
            delta = ~delta & mask;
        end
        // arithmetic shift right at sample width
        half = (delta >> 1) | (delta & (i_ctrl.wide ? 16'h8000 : 16'h0080));
        base   = i_ctrl.use_pred ? r_pred : r_prev;
        sample = (delta + base) & mask;
    end

    // prediction update, in the cycle after the sample is formed
    always_comb begin
        s_ext = sext(r_samp, i_ctrl.wide);
        h_ext = sext(r_half, i_ctrl.wide);
        p_ext = sext(r_prev, i_ctrl.wide);
        nx    = (s_ext <<< 1) + h_ext - p_ext;
        lim   = i_ctrl.wide ? 19'sd32767 : 19'sd127;
        if (nx > lim) begin
            sat = lim;
        end else if (nx < -lim - 19'sd1) begin
            sat = -lim - 19'sd1;
        end else begin
            sat = nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.restart) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_prev      <= '0;
            r_pred      <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_pend) begin
                r_pred <= sat[SAMPLE_W-1:0] & mask;
                r_prev <= r_samp;
                r_pend <= 1'b0;
            end else if (o_pop) begin
                if (i_ctrl.use_pred) begin
                    r_pend <= 1'b1;
                end else begin
                    r_prev <= sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_value <= sample;
            r_out_final <= i_item.last;
            r_samp      <= sample;
            r_half      <= half;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_final_sample = r_out_final;

    a_pend_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> i_ctrl.use_pred) else $error("prediction step without prediction mode");
    a_narrow_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ctrl.wide) |-> (r_out_value[15:8] == 8'h00))
        else $error("upper byte set in 8-bit mode");

endmodule

`default_nettype wire

[test/adaptive_delta_sample_decoder_tb.sv]
// Self-checking testbench for adaptive_delta_sample_decoder.
// Predicts every decoded sample from the bytes sent and compares it with the DUT output.
// Depends on ads_pkg and the design sources only.
`timescale 1ns / 100ps

module adaptive_delta_sample_decoder_tb;
    import ads_pkg::*;

    // register index with no register behind it; a write there must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    // covers the parse of one byte plus queue and output stages; generous margin
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_stream_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_sample_value;
    logic        o_final_sample;

    adaptive_delta_sample_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_stream_byte  (i_stream_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_value (o_sample_value),
        .o_final_sample (o_final_sample)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model: register copies and parse state, advanced one byte
    // at a time when the byte is accepted.
    // ------------------------------------------------------------------
    logic        cfg_wide;
    logic        cfg_pred;
    logic [23:0] cfg_count;

    logic [3:0]  lp_width;      // adaptive low part width
    logic [15:0] code_acc;      // code word being shifted in
    t_phase      phase;
    logic [1:0]  grp_pos;       // data bits taken in the current group
    logic [3:0]  low_left;      // low part bits still to come
    logic [15:0] last_sample;
    logic [15:0] pred_sample;
    logic [23:0] remaining;     // samples still to decode

    t_sample     pending_samples[$];

    int send_idle_pct  = 10;
    int recv_stall_pct = 49;
    int errors         = 0;
    int bytes_sent     = 0;
    int samples_seen   = 0;
    int finals_seen    = 0;
    int settings_made  = 0;
    int cycle_count    = 0;

    function automatic void restart_decoder();
        lp_width    = cfg_wide ? 4'd8 : 4'd4;
        code_acc    = '0;
        phase       = PH_DATA;
        grp_pos     = '0;
        low_left    = '0;
        last_sample = '0;
        pred_sample = '0;
        remaining   = cfg_count;
    endfunction

    // sign-extend at the current sample width
    function automatic int as_signed(logic [15:0] v);
        return cfg_wide ? int'($signed(v)) : int'($signed(v[7:0]));
    endfunction

    // close the code word: adapt the width, form the delta, produce the sample
    function automatic logic [15:0] close_sample();
        logic [15:0] mask;
        logic [15:0] code;
        logic [15:0] delta;
        logic [15:0] half;
        logic [15:0] smp;
        int          nbits;
        int          top;
        int          lim;
        int          nx;
        mask  = cfg_wide ? 16'hFFFF : 16'h00FF;
        nbits = cfg_wide ? 16 : 8;
        code  = code_acc & mask;
        top   = 1;
        if (code >= 16'd4) begin
            top = nbits - 1;
            while (code[top] == 1'b0 && top > 1)
                top--;
        end
        lp_width = 4'((lp_width + top) >> 1);
        delta = code >> 1;
        // clear sign bit: the magnitude is stored complemented
        if (!code[0])
            delta = ~delta & mask;
        if (cfg_pred) begin
            lim  = cfg_wide ? 32767 : 127;
            // arithmetic halving at sample width
            half = (delta >> 1) | (delta & (16'h1 << (nbits - 1)));
            smp  = (delta + pred_sample) & mask;
            nx   = 2 * as_signed(smp) + as_signed(half) - as_signed(last_sample);
            if (nx > lim)
                nx = lim;
            else if (nx < -lim - 1)
                nx = -lim - 1;
            pred_sample = 16'(nx) & mask;
        end else begin
            smp = (delta + last_sample) & mask;
        end
        last_sample = smp;
        code_acc    = '0;
        phase       = PH_DATA;
        grp_pos     = '0;
        low_left    = '0;
        remaining   = remaining - 24'd1;
        return smp;
    endfunction

    // walk the bits of one byte MSB first and queue every finished sample
    function automatic void decode_byte(logic [7:0] b);
        logic [15:0] mask;
        logic        done;
        int          per;
        t_sample     s;
        mask = cfg_wide ? 16'hFFFF : 16'h00FF;
        for (int i = 7; i >= 0; i--) begin
            done = 1'b0;
            // count exhausted: rest of the stream is dropped
            if (remaining == '0)
                break;
            case (phase)
                PH_DATA: begin
                    // two data bits per group in wide mode while the width is narrow
                    per = (cfg_wide && lp_width < 4'd5) ? 2 : 1;
                    code_acc = ((code_acc << 1) | 16'(b[i])) & mask;
                    grp_pos++;
                    if (grp_pos >= per) begin
                        grp_pos = '0;
                        phase   = PH_CONT;
                    end
                end
                PH_CONT: begin
                    if (b[i]) begin
                        phase = PH_DATA;
                    end else begin
                        low_left = lp_width;
                        phase    = PH_LOW;
                        if (low_left == '0)
                            done = 1'b1;
                    end
                end
                default: begin
                    code_acc = ((code_acc << 1) | 16'(b[i])) & mask;
                    if (low_left > '0)
                        low_left--;
                    if (low_left == '0)
                        done = 1'b1;
                end
            endcase
            if (done) begin
                s.value = close_sample();
                s.last  = (remaining == '0);
                pending_samples.push_back(s);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random back-pressure and the sample checker.
    // Both sample DUT outputs right at the rising edge, before it updates.
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin : check_samples
        t_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample: value %h final %b",
                         $time, o_sample_value, o_final_sample);
                errors++;
            end else begin
                want = pending_samples.pop_front();
                samples_seen++;
                if (o_final_sample)
                    finals_seen++;
                if (o_sample_value !== want.value) begin
                    $display("%0t: sample value: expected %h, actual %h",
                             $time, want.value, o_sample_value);
                    errors++;
                end
                if (o_final_sample !== want.last) begin
                    $display("%0t: final flag: expected %b, actual %b",
                             $time, want.last, o_final_sample);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d samples outstanding",
                     $time, cycle_count, pending_samples.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All called right after a rising edge.
    // ------------------------------------------------------------------

    // offer one byte, optionally after an idle gap, and wait for acceptance;
    // gaps can outlast the parse of a byte so the front end also sees no byte
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        decode_byte(b);
    endtask

    // stop sending, let every expected sample drain, then let the parser go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; a valid index restarts the decoder
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDE:  cfg_wide  = data[0];
            CFG_PRED:  cfg_pred  = data[0];
            CFG_COUNT: cfg_count = data;
            default: ;
        endcase
        if (idx != CFG_UNUSED) begin
            restart_decoder();
            settings_made++;
        end
        @(posedge i_clk);
    endtask

    // mostly random bytes, with all-zero and all-one bytes mixed in:
    // zeros shrink the width, ones build long high parts that overflow the code word
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // count of zero drops all bytes; an unused index leaves the parse untouched;
    // bytes after the last sample are ignored
    task automatic test_count_and_unused_index();
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();
        write_reg(CFG_COUNT, 24'd2);
        send_byte(8'h00);
        settle();
        // mid code word: this write must not restart anything
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hA5);
        settle();
    endtask

    // every mode combination with a short count, long high parts and zero runs
    task automatic test_modes_directed();
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_WIDE, 24'(m & 1));
            write_reg(CFG_PRED, 24'(m >> 1));
            write_reg(CFG_COUNT, 24'd3);
            send_byte(8'hFF);
            send_byte(8'h00);
            send_byte(8'h80);
            send_byte(8'h01);
            settle();
        end
    endtask

    // random settings and streams; junk in unused data bits of the mode registers
    task automatic test_random_streams(input int segments);
        logic [23:0] count;
        logic        wide;
        logic        pred;
        logic        count_first;
        int          nbytes;
        for (int s = 0; s < segments; s++) begin
            wide = 1'($urandom);
            pred = 1'($urandom);
            case ($urandom_range(9))
                0:       count = 24'd1;
                1:       count = 24'hFFFFFF;
                2:       count = 24'd0;
                default: count = 24'($urandom_range(2, 30));
            endcase
            count_first = 1'($urandom);
            if (count_first)
                write_reg(CFG_COUNT, count);
            write_reg(CFG_WIDE, (24'($urandom) & ~24'h1) | 24'(wide));
            write_reg(CFG_PRED, (24'($urandom) & ~24'h1) | 24'(pred));
            if (!count_first)
                write_reg(CFG_COUNT, count);
            if ($urandom_range(3) == 0)
                write_reg(CFG_UNUSED, 24'($urandom));
            nbytes = $urandom_range(20, 36);
            repeat (nbytes) send_byte(pick_byte());
            settle();
        end
    endtask

    initial begin
        cfg_wide  = 1'b0;
        cfg_pred  = 1'b0;
        cfg_count = '0;
        restart_decoder();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles rarely, receiver stalls about half the time
        send_idle_pct  = 10;
        recv_stall_pct = 49;
        test_count_and_unused_index();
        test_modes_directed();
        test_random_streams(6);

        // roles swapped
        send_idle_pct  = 49;
        recv_stall_pct = 10;
        test_random_streams(6);

        // full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_streams(6);

        settle();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d bytes over %0d register settings in 8/16-bit and prediction modes,",
                 bytes_sent, settings_made);
        $display("checked %0d samples, %0d of them flagged final.", samples_seen, finals_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
